// ===== rtl/ipv4_cidr_port_parser_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker of the address parser.
// ---------------------------------------------------------------------------
`ifndef IPV4_CIDR_PORT_PARSER_MACROS_SVH
`define IPV4_CIDR_PORT_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define IPCP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IPCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ipcp_pkg.sv =====
// ---------------------------------------------------------------------------
// ipcp_pkg
// Types, character codes and helpers of the IPv4 address/prefix/port parser.
// ---------------------------------------------------------------------------
package ipcp_pkg;

	localparam logic [7:0] CH_TERM  = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [5:0]  PREFIX_DEFAULT = 6'd32;
	localparam logic [19:0] OCTET_LIMIT    = 20'd255;
	localparam logic [19:0] PREFIX_LIMIT   = 20'd32;
	localparam logic [19:0] PORT_LIMIT     = 20'd65535;

	typedef struct packed {
		logic        ok;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [15:0] port_number;
		logic [31:0] network;
	} ipcp_result_t;

	// low-bit mask: len bits set, none for zero, all for 32 and above
	function automatic logic [31:0] low_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'd0;
		end else if (len >= 6'd32) begin
			m = 32'hffff_ffff;
		end else begin
			m = 32'hffff_ffff >> (6'd32 - len);
		end
		return m;
	endfunction

endpackage

// ===== rtl/ipv4_cidr_port_parser.sv =====
// ---------------------------------------------------------------------------
// ipv4_cidr_port_parser
// Streaming parser for text of the form a.b.c.d[/p]:port.
// ---------------------------------------------------------------------------
// Takes one character per request on the char channel, a zero byte ending the
// string, and gives one request on the res channel per terminator: ok, the
// address with the first octet in bits 7..0, the prefix length (32 if no slash
// part), the port, and the address ANDed with a mask of prefix_len low bits.
// Any error (empty number, value over 255/32/65535, stray character, early
// terminator) is latched, later characters are dropped, and the terminator
// still yields one result with ok = 0 and every other field 0; the parser
// then starts over. A character is held in the input register and is folded
// into the parse state at the edge at which the scan takes it; a terminator
// writes the result register at that same edge. Throughput is one character
// per cycle while nothing stalls. The only back-pressure is a terminator that
// reaches the input register while the previous result is still stalled: it
// waits there until that result is taken, and char_stall stays high meanwhile.
// ---------------------------------------------------------------------------
module ipv4_cidr_port_parser
	import ipcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        ok,
	output logic [31:0] address,
	output logic [5:0]  prefix_len,
	output logic [15:0] port_number,
	output logic [31:0] network
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         adv;
	logic         term_s1;
	logic         res_fire;
	logic         res_valid_q;
	ipcp_result_t res;
	ipcp_result_t res_q;

	// input register
	ipcp_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.char_s1    (char_s1)
	);

	// a held terminator needs a free (or freeing) result slot
	assign term_s1  = (char_s1 == CH_TERM);
	assign adv      = !(term_s1 && res_valid_q && res_stall);
	assign res_fire = valid_s1 && adv && term_s1;

	// parse state, advanced once per character taken from the input register
	ipcp_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && adv),
		.char_s1 (char_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			res_q <= res;
		end
	end

	assign res_valid   = res_valid_q;
	assign ok          = res_q.ok;
	assign address     = res_q.address;
	assign prefix_len  = res_q.prefix_len;
	assign port_number = res_q.port_number;
	assign network     = res_q.network;

endmodule

// ===== rtl/ipcp_in_reg.sv =====
// ---------------------------------------------------------------------------
// ipcp_in_reg
// Input register of the parser: holds one character until the scan takes it.
// ---------------------------------------------------------------------------
module ipcp_in_reg
	import ipcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] char_s1
);

	logic load;

	// the held character can only be blocked by a pending result
	assign char_stall = valid_s1 && !adv;
	assign load       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= char_code;
		end
	end

endmodule

// ===== rtl/ipcp_scan.sv =====
// ---------------------------------------------------------------------------
// ipcp_scan
// Parse state and per-character update; forms the result on the terminator.
// ---------------------------------------------------------------------------
module ipcp_scan
	import ipcp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   char_s1,
	output ipcp_result_t res
);

	localparam logic [2:0] PH_OCT0   = 3'd0;
	localparam logic [2:0] PH_OCT2   = 3'd2;
	localparam logic [2:0] PH_OCT3   = 3'd3;
	localparam logic [2:0] PH_PREFIX = 3'd4;
	localparam logic [2:0] PH_PORT   = 3'd5;

	logic [2:0]  phase_q,  phase_d;
	logic [15:0] acc_q,    acc_d;
	logic        seen_q,   seen_d;
	logic        failed_q, failed_d;
	logic [31:0] addr_q,   addr_d;
	logic [5:0]  prefix_q, prefix_d;

	logic        is_digit;
	logic        is_term;
	logic [19:0] acc_next;
	logic [19:0] limit;
	logic        good;

	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_term  = (char_s1 == CH_TERM);

	// acc * 10 + digit as two shifts and adds
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {16'd0, char_s1[3:0]};

	always_comb begin
		case (phase_q)
			PH_PREFIX: limit = PREFIX_LIMIT;
			PH_PORT:   limit = PORT_LIMIT;
			default:   limit = (phase_q <= PH_OCT3) ? OCTET_LIMIT : PORT_LIMIT;
		endcase
	end

	always_comb begin
		logic sep_ok;
		sep_ok   = 1'b0;
		phase_d  = phase_q;
		acc_d    = acc_q;
		seen_d   = seen_q;
		failed_d = failed_q;
		addr_d   = addr_q;
		prefix_d = prefix_q;
		if (step) begin
			if (is_term) begin
				phase_d  = PH_OCT0;
				acc_d    = 16'd0;
				seen_d   = 1'b0;
				failed_d = 1'b0;
				addr_d   = 32'd0;
				prefix_d = PREFIX_DEFAULT;
			end else if (!failed_q) begin
				if (is_digit) begin
					if (phase_q > PH_PORT || acc_next > limit) begin
						failed_d = 1'b1;
					end else begin
						acc_d  = acc_next[15:0];
						seen_d = 1'b1;
					end
				end else if (!seen_q) begin
					failed_d = 1'b1;
				end else begin
					sep_ok = 1'b1;
					if (phase_q <= PH_OCT2 && char_s1 == CH_DOT) begin
						addr_d[{phase_q[1:0], 3'b000} +: 8] = acc_q[7:0];
						phase_d = phase_q + 3'd1;
					end else if (phase_q == PH_OCT3
						&& (char_s1 == CH_SLASH || char_s1 == CH_COLON)) begin
						addr_d[31:24] = acc_q[7:0];
						phase_d = (char_s1 == CH_SLASH) ? PH_PREFIX : PH_PORT;
					end else if (phase_q == PH_PREFIX && char_s1 == CH_COLON) begin
						prefix_d = acc_q[5:0];
						phase_d  = PH_PORT;
					end else begin
						failed_d = 1'b1;
						sep_ok   = 1'b0;
					end
					if (sep_ok) begin
						acc_d  = 16'd0;
						seen_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OCT0;
			acc_q    <= 16'd0;
			seen_q   <= 1'b0;
			failed_q <= 1'b0;
			addr_q   <= 32'd0;
			prefix_q <= PREFIX_DEFAULT;
		end else begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			seen_q   <= seen_d;
			failed_q <= failed_d;
			addr_q   <= addr_d;
			prefix_q <= prefix_d;
		end
	end

	// result as seen on a terminator; all fields zero on failure
	assign good = !failed_q && phase_q == PH_PORT && seen_q;

	always_comb begin
		res.ok          = good;
		res.address     = good ? addr_q : 32'd0;
		res.prefix_len  = good ? prefix_q : 6'd0;
		res.port_number = good ? acc_q : 16'd0;
		res.network     = good ? (addr_q & low_mask(prefix_q)) : 32'd0;
	end

endmodule

// ===== rtl/ipcp_checker.sv =====
// ---------------------------------------------------------------------------
// ipcp_checker
// Port-level checks of the parser's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "ipv4_cidr_port_parser_macros.svh"

module ipcp_checker
	import ipcp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic        ok,
	input logic [31:0] address,
	input logic [5:0]  prefix_len,
	input logic [15:0] port_number,
	input logic [31:0] network
);

	`IPCP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(ok) && $stable(address) && $stable(port_number) && $stable(network), "stalled result changed")
	`IPCP_ASSERT_IMPL(a_fail_zero, res_valid && !ok, address == 32'd0 && prefix_len == 6'd0 && port_number == 16'd0 && network == 32'd0, "failed result not cleared")
	`IPCP_ASSERT_IMPL(a_prefix_range, res_valid && ok, prefix_len <= PREFIX_DEFAULT, "prefix length over 32")
	`IPCP_ASSERT_IMPL(a_net_subset, res_valid && ok, (network & ~address) == 32'd0, "network has bits outside address")

endmodule

bind ipv4_cidr_port_parser ipcp_checker u_ipcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.ok          (ok),
	.address     (address),
	.prefix_len  (prefix_len),
	.port_number (port_number),
	.network     (network)
);

// ===== dv/ipv4_cidr_port_parser_test.sv =====
// ---------------------------------------------------------------------------
// ipv4_cidr_port_parser_test
// Self-checking bench for the streaming a.b.c.d[/p]:port parser.
// ---------------------------------------------------------------------------
// Characters go in on the char channel, one request per character, each
// string ending in a zero byte. A scoreboard object parses every accepted
// character on its own and queues the result a terminator should produce;
// results taken on the res channel are checked field by field against the
// oldest queued one. Stimulus is a few hand-picked strings, then random
// strings: mostly well-formed with random values, some with one corruption,
// some pure noise. The run steps through four idling mixes on both channels.
// ---------------------------------------------------------------------------
module ipv4_cidr_port_parser_test;
	import ipcp_pkg::*;

	// parser position within the text
	typedef enum logic [2:0] {
		PH_OCT0,
		PH_OCT1,
		PH_OCT2,
		PH_OCT3,
		PH_PREFIX,
		PH_PORT
	} parse_phase_t;

	// -----------------------------------------------------------------------
	// Scoreboard: character-level parser plus the queue of expected results
	// -----------------------------------------------------------------------
	class parse_scoreboard;
		ipcp_result_t  expected_q[$];
		parse_phase_t  phase;
		int unsigned   acc;
		bit            digit_seen;
		bit            failed;
		logic [31:0]   addr;
		logic [5:0]    pfx;
		int            mismatches;
		int            results_seen;
		int            ok_results;

		function new();
			restart();
			mismatches   = 0;
			results_seen = 0;
			ok_results   = 0;
		endfunction

		function void restart();
			phase      = PH_OCT0;
			acc        = 0;
			digit_seen = 0;
			failed     = 0;
			addr       = '0;
			pfx        = PREFIX_DEFAULT;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// fold one accepted character into the parse; terminator queues a result
		function void note_char(logic [7:0] c);
			ipcp_result_t r;
			int unsigned  v;
			int unsigned  limit;
			if (c == CH_TERM) begin
				r = '0;
				if (!failed && phase == PH_PORT && digit_seen) begin
					r.ok          = 1'b1;
					r.address     = addr;
					r.prefix_len  = pfx;
					r.port_number = acc[15:0];
					// low pfx bits set; nothing for a zero prefix
					r.network     = addr & ((pfx == 0) ? 32'd0 : (32'hffff_ffff >> (32 - pfx)));
				end
				expected_q.push_back(r);
				restart();
				return;
			end
			if (failed) begin
				return;
			end
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = acc * 10 + (c - CH_ZERO);
				if (phase <= PH_OCT3) begin
					limit = OCTET_LIMIT;
				end else if (phase == PH_PREFIX) begin
					limit = PREFIX_LIMIT;
				end else begin
					limit = PORT_LIMIT;
				end
				if (v > limit) begin
					failed = 1;
				end else begin
					acc        = v;
					digit_seen = 1;
				end
				return;
			end
			// any separator or other non-digit character needs a digit before it
			if (!digit_seen) begin
				failed = 1;
				return;
			end
			if (phase <= PH_OCT2 && c == CH_DOT) begin
				addr  = addr | ((acc & 32'hff) << (8 * int'(phase)));
				phase = parse_phase_t'(phase + 1);
			end else if (phase == PH_OCT3 && (c == CH_SLASH || c == CH_COLON)) begin
				addr[31:24] = acc[7:0];
				phase       = (c == CH_SLASH) ? PH_PREFIX : PH_PORT;
			end else if (phase == PH_PREFIX && c == CH_COLON) begin
				pfx   = acc[5:0];
				phase = PH_PORT;
			end else begin
				failed = 1;
				return;
			end
			acc        = 0;
			digit_seen = 0;
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 40) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
			mismatches++;
		endtask

		task check_result(ipcp_result_t got);
			ipcp_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch("result with none outstanding");
				return;
			end
			want = expected_q.pop_front();
			if (want.ok) begin
				ok_results++;
			end
			if (got.ok !== want.ok) begin
				report_mismatch($sformatf("ok %0b, want %0b", got.ok, want.ok));
			end
			if (got.address !== want.address) begin
				report_mismatch($sformatf("address %h, want %h", got.address, want.address));
			end
			if (got.prefix_len !== want.prefix_len) begin
				report_mismatch($sformatf("prefix_len %0d, want %0d",
					got.prefix_len, want.prefix_len));
			end
			if (got.port_number !== want.port_number) begin
				report_mismatch($sformatf("port_number %0d, want %0d",
					got.port_number, want.port_number));
			end
			if (got.network !== want.network) begin
				report_mismatch($sformatf("network %h, want %h", got.network, want.network));
			end
		endtask
	endclass

	// -----------------------------------------------------------------------
	// DUT and its signals
	// -----------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  char_code;
	logic        res_valid;
	logic        res_stall;
	logic        ok;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic [15:0] port_number;
	logic [31:0] network;

	ipv4_cidr_port_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.ok          (ok),
		.address     (address),
		.prefix_len  (prefix_len),
		.port_number (port_number),
		.network     (network)
	);

	parse_scoreboard sb = new();

	// idling mix, percent of cycles
	int          send_idle_pct;
	int          stall_pct;
	int          lines_sent;
	int          chars_sent;
	int          phase_chars;
	logic [7:0]  line_q[$];
	ipcp_result_t got_r;

	// hand-picked strings: all-zero with zero prefix, field maxima,
	// bare terminator, stray slash, empty first octet, octet over 255
	string directed_lines[6] = '{
		"0.0.0.0/0:0",
		"255.1.2.255/32:65535",
		"",
		"9/",
		".1",
		"256x"
	};

	// -----------------------------------------------------------------------
	// Clock, reset, run limit
	// -----------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[ipv4_cidr_port_parser] ERROR");
		$finish;
	end

	// receiver: random stall, changed on the falling edge
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// monitor: both handshakes sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				sb.note_char(char_code);
			end
			if (res_valid && !res_stall) begin
				got_r.ok          = ok;
				got_r.address     = address;
				got_r.prefix_len  = prefix_len;
				got_r.port_number = port_number;
				got_r.network     = network;
				sb.check_result(got_r);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Driver: one character per request, idle gaps before raising valid
	// -----------------------------------------------------------------------
	task automatic push_char(input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= c;
		// accepted at the first rising edge without stall
		do begin
			@(posedge clk);
		end while (char_stall);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i]) begin
			push_char(line_q[i]);
		end
		push_char(CH_TERM);
		phase_chars += line_q.size() + 1;
		lines_sent++;
	endtask

	// drop valid and hold off until every result is back
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// -----------------------------------------------------------------------
	// Text generation
	// -----------------------------------------------------------------------
	// half from the parser's own alphabet, half any non-zero byte
	function automatic logic [7:0] noise_char();
		int k;
		k = $urandom_range(15);
		if (k < 5) begin
			return CH_ZERO + 8'($urandom_range(9));
		end else if (k == 5) begin
			return CH_DOT;
		end else if (k == 6) begin
			return CH_SLASH;
		end else if (k == 7) begin
			return CH_COLON;
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// extremes often, up to ten past the limit now and then
	function automatic int unsigned pick_value(int unsigned limit);
		int k;
		k = $urandom_range(19);
		if (k == 0) begin
			return 0;
		end else if (k < 3) begin
			return limit;
		end else if (k == 3) begin
			return limit + 1 + $urandom_range(9);
		end
		return $urandom_range(limit);
	endfunction

	function automatic void append_number(int unsigned value);
		logic [7:0]  digits[$];
		int unsigned v;
		v = value;
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(1, 3)) line_q.push_back(CH_ZERO);
		end
		do begin
			digits.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i]) begin
			line_q.push_back(digits[i]);
		end
	endfunction

	function automatic void build_wellformed();
		line_q.delete();
		for (int i = 0; i < 4; i++) begin
			append_number(pick_value(OCTET_LIMIT));
			if (i < 3) begin
				line_q.push_back(CH_DOT);
			end
		end
		if ($urandom_range(1)) begin
			line_q.push_back(CH_SLASH);
			append_number(pick_value(PREFIX_LIMIT));
		end
		line_q.push_back(CH_COLON);
		append_number(pick_value(PORT_LIMIT));
	endfunction

	// one damage: overwrite, drop, insert, or cut short
	function automatic void corrupt_line();
		int pos;
		pos = $urandom_range(line_q.size() - 1);
		case ($urandom_range(3))
			0: begin
				line_q[pos] = noise_char();
			end
			1: begin
				line_q.delete(pos);
			end
			2: begin
				line_q.insert(pos, noise_char());
			end
			default: begin
				while (line_q.size() > pos) line_q.pop_back();
			end
		endcase
	endfunction

	function automatic void build_noise();
		line_q.delete();
		repeat ($urandom_range(10)) line_q.push_back(noise_char());
	endfunction

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		char_valid    = 1'b0;
		char_code     = CH_TERM;
		res_stall     = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		lines_sent    = 0;
		chars_sent    = 0;
		phase_chars   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed strings, no idling
		foreach (directed_lines[n]) begin
			line_q.delete();
			for (int i = 0; i < directed_lines[n].len(); i++) begin
				line_q.push_back(directed_lines[n][i]);
			end
			send_line();
		end
		drain();

		// random strings under four idling mixes
		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 83;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 83;
				end
				default: begin
					send_idle_pct = 9;
					stall_pct     = 9;
				end
			endcase
			phase_chars = 0;
			while (phase_chars < 365) begin
				if ($urandom_range(99) < 80) begin
					build_wellformed();
					if ($urandom_range(99) < 30) begin
						corrupt_line();
					end
				end else begin
					build_noise();
				end
				send_line();
			end
			// every mix ends with the sender held back until all results are in
			drain();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d strings, %0d characters; %0d results checked, %0d parsed ok",
			lines_sent, chars_sent, sb.results_seen, sb.ok_results);
		$display("idling mixes: none, sender 83%%, receiver 83%%, both 9%%; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("[ipv4_cidr_port_parser] OK");
		end else begin
			$display("[ipv4_cidr_port_parser] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ipcp_pkg.sv
rtl/ipcp_in_reg.sv
rtl/ipcp_scan.sv
rtl/ipv4_cidr_port_parser.sv
rtl/ipcp_checker.sv
dv/ipv4_cidr_port_parser_test.sv
